@@ rtl/phlm_pkg.sv @@
// Shared types, constants and control records of the peak hold level meter.
package phlm_pkg;

  localparam int CHANNELS  = 64;
  localparam int CH_W      = 6;
  localparam int DB_W      = 16;
  localparam int MS_W      = 16;
  localparam int RATE_W    = 16;
  localparam int ACT_W     = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic signed [DB_W-1:0] RST_FLOOR      = -16'sd15360;
  localparam logic [RATE_W-1:0]      RST_LEVEL_RATE = 16'd3932;
  localparam logic [RATE_W-1:0]      RST_PEAK_RATE  = 16'd786;
  localparam logic [MS_W-1:0]        RST_HOLD_TIME  = 16'd1500;
  localparam logic [ACT_W-1:0]       RST_ACTIVE     = 7'd2;

  typedef enum logic [1:0] {
    MODE_DECAY   = 2'd0,
    MODE_OBSERVE = 2'd1,
    MODE_CLEAR   = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLOOR      = 3'd0,
    CFG_LEVEL_RATE = 3'd1,
    CFG_PEAK_RATE  = 3'd2,
    CFG_HOLD_TIME  = 3'd3,
    CFG_ACTIVE     = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_READ  = 2'd1,
    ST_MULT  = 2'd2,
    ST_WRITE = 2'd3
  } state_t;

  typedef struct packed {
    logic            load;
    logic            rd;
    logic            mul;
    logic            wr;
    logic [CH_W-1:0] ch;
    logic            last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic            out_free;
    logic [CH_W-1:0] last_ch;
  } dp_status_t;

endpackage

@@ rtl/phlm_in_if.sv @@
// Input channel: one request for decay, observe or clear.
interface phlm_in_if import phlm_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [1:0]             mode;
  logic [CH_W-1:0]        channel;
  logic signed [DB_W-1:0] level_db;
  logic [MS_W-1:0]        time_ms;

  modport source (output valid, mode, channel, level_db, time_ms, input ready);
  modport sink (input valid, mode, channel, level_db, time_ms, output ready);
endinterface

@@ rtl/phlm_out_if.sv @@
// Result channel: the updated values of one channel.
interface phlm_out_if import phlm_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [CH_W-1:0]        channel_index;
  logic signed [DB_W-1:0] level_out;
  logic signed [DB_W-1:0] peak_out;
  logic [MS_W-1:0]        hold_out;
  logic                   last;

  modport source (output valid, channel_index, level_out, peak_out, hold_out, last,
                  input ready);
  modport sink (input valid, channel_index, level_out, peak_out, hold_out, last,
                output ready);
endinterface

@@ rtl/phlm_cfg_if.sv @@
// Configuration write channel: register index and write data.
interface phlm_cfg_if import phlm_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/phlm_ctrl.sv @@
// Controller that sequences the read, multiply and write steps of every channel.
module phlm_ctrl import phlm_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [1:0]      in_mode,
  input  logic [CH_W-1:0] in_channel,
  output logic            in_ready,
  input  dp_status_t      status,
  output ctrl_cmd_t       cmd
);

  state_t          state_r, state_nxt;
  logic [CH_W-1:0] ch_r, ch_nxt;
  logic [CH_W-1:0] last_r, last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ch_r    <= '0;
      last_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      last_r  <= last_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    last_nxt  = last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (mode_t'(in_mode))
            MODE_OBSERVE: begin
              ch_nxt    = in_channel;
              last_nxt  = in_channel;
              state_nxt = ST_READ;
            end
            MODE_DECAY, MODE_CLEAR: begin
              ch_nxt    = '0;
              last_nxt  = status.last_ch;
              state_nxt = ST_READ;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_READ:  state_nxt = ST_MULT;
      ST_MULT:  state_nxt = ST_WRITE;
      ST_WRITE: begin
        if (status.out_free) begin
          if (ch_r == last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            ch_nxt    = ch_r + 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == ST_IDLE);
    cmd.load = (state_r == ST_IDLE) && in_valid;
    cmd.rd   = (state_r == ST_READ);
    cmd.mul  = (state_r == ST_MULT);
    cmd.wr   = (state_r == ST_WRITE) && status.out_free;
    cmd.ch   = ch_r;
    cmd.last = (ch_r == last_r);
  end

endmodule

@@ rtl/phlm_dp.sv @@
// Datapath: configuration registers, channel state memory, rate multipliers and result register.
module phlm_dp import phlm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DAT_W-1:0]   cfg_data,
  input  logic [1:0]             in_mode,
  input  logic signed [DB_W-1:0] in_level_db,
  input  logic [MS_W-1:0]        in_time_ms,
  input  ctrl_cmd_t              cmd,
  output dp_status_t             status,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [CH_W-1:0]        out_channel_index,
  output logic signed [DB_W-1:0] out_level,
  output logic signed [DB_W-1:0] out_peak,
  output logic [MS_W-1:0]        out_hold,
  output logic                   out_last
);

  localparam int ENTRY_W = 2 * DB_W + MS_W;
  localparam int WIDE_W  = 26;
  localparam int PROD_W  = RATE_W + MS_W;

  function automatic logic signed [DB_W-1:0] sat_floor(
    input logic signed [WIDE_W-1:0] v,
    input logic signed [DB_W-1:0]   f
  );
    logic signed [WIDE_W-1:0] f_w;
    f_w = {{(WIDE_W-DB_W){f[DB_W-1]}}, f};
    if (v < f_w) return f;
    else return v[DB_W-1:0];
  endfunction

  function automatic logic signed [WIDE_W-1:0] widen(input logic signed [DB_W-1:0] v);
    return {{(WIDE_W-DB_W){v[DB_W-1]}}, v};
  endfunction

  logic signed [DB_W-1:0] floor_r;
  logic [RATE_W-1:0]      lrate_r, prate_r;
  logic [MS_W-1:0]        hold_time_r;
  logic [ACT_W-1:0]       act_r;

  mode_t                  mode_r;
  logic signed [DB_W-1:0] db_r, db_nxt;
  logic [MS_W-1:0]        t_r;

  logic [ENTRY_W-1:0]     mem [CHANNELS];
  logic [CHANNELS-1:0]    valid_r;
  logic [ENTRY_W-1:0]     mem_q_r;
  logic                   vld_q_r;

  logic [PROD_W-1:0]      prod_l_r, prod_p_r;

  logic                   out_valid_r;
  logic [CH_W-1:0]        out_ch_r;
  logic signed [DB_W-1:0] out_lvl_r, out_pk_r;
  logic [MS_W-1:0]        out_hold_r;
  logic                   out_last_r;

  logic signed [DB_W-1:0] eff_floor;
  logic signed [DB_W-1:0] lvl, pk;
  logic [MS_W-1:0]        hold, over, left;
  logic signed [WIDE_W-1:0] fall_l, fall_p, cand, held, pk_w;
  logic signed [DB_W-1:0] cand_s;
  logic signed [DB_W-1:0] new_lvl, new_pk;
  logic [MS_W-1:0]        new_hold;

  // A positive floor acts as a floor of 0.
  assign eff_floor = (!floor_r[DB_W-1] && (floor_r != '0)) ? '0 : floor_r;

  always_comb begin
    if (act_r == '0) status.last_ch = '0;
    else if (act_r[ACT_W-1]) status.last_ch = '1;
    else status.last_ch = act_r[CH_W-1:0] - 1'b1;
    status.out_free = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r     <= RST_FLOOR;
      lrate_r     <= RST_LEVEL_RATE;
      prate_r     <= RST_PEAK_RATE;
      hold_time_r <= RST_HOLD_TIME;
      act_r       <= RST_ACTIVE;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_FLOOR:      floor_r     <= cfg_data;
        CFG_LEVEL_RATE: lrate_r     <= cfg_data;
        CFG_PEAK_RATE:  prate_r     <= cfg_data;
        CFG_HOLD_TIME:  hold_time_r <= cfg_data;
        CFG_ACTIVE:     act_r       <= cfg_data[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    db_nxt = in_level_db;
    if (db_nxt < eff_floor) db_nxt = eff_floor;
    if (db_nxt > 16'sd0) db_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode_t'(in_mode);
      db_r   <= db_nxt;
      t_r    <= in_time_ms;
    end
  end

  // Entries never written read as the reset state of a channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.wr) begin
      valid_r[cmd.ch] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[cmd.ch] <= {new_lvl, new_pk, new_hold};
    end
    if (cmd.rd) begin
      mem_q_r <= mem[cmd.ch];
      vld_q_r <= valid_r[cmd.ch];
    end
  end

  always_comb begin
    if (vld_q_r) begin
      {lvl, pk, hold} = mem_q_r;
    end else begin
      lvl  = RST_FLOOR;
      pk   = RST_FLOOR;
      hold = '0;
    end
  end

  always_comb begin
    if (mode_r == MODE_OBSERVE) over = (t_r > hold_time_r) ? t_r - hold_time_r : '0;
    else over = (t_r > hold) ? t_r - hold : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_l_r <= PROD_W'(lrate_r) * PROD_W'(t_r);
      prod_p_r <= PROD_W'(prate_r) * PROD_W'(over);
    end
  end

  always_comb begin
    fall_l   = {2'b00, prod_l_r[PROD_W-1:8]};
    fall_p   = {2'b00, prod_p_r[PROD_W-1:8]};
    pk_w     = widen(pk);
    left     = (hold_time_r > t_r) ? hold_time_r - t_r : '0;
    cand     = widen(db_r) - fall_l;
    cand_s   = sat_floor(cand, eff_floor);
    held     = widen(db_r) - fall_p;
    new_lvl  = lvl;
    new_pk   = pk;
    new_hold = hold;
    case (mode_r)
      MODE_OBSERVE: begin
        if (cand_s > lvl) new_lvl = cand_s;
        if ((held >= pk_w) && (db_r > eff_floor)) begin
          if (held > pk_w) new_hold = left;
          else if (left > hold) new_hold = left;
          new_pk = sat_floor(held, eff_floor);
        end
      end
      MODE_DECAY: begin
        new_lvl  = sat_floor(widen(lvl) - fall_l, eff_floor);
        new_pk   = sat_floor(pk_w - fall_p, eff_floor);
        new_hold = (hold > t_r) ? hold - t_r : '0;
      end
      MODE_CLEAR: begin
        new_lvl  = eff_floor;
        new_pk   = eff_floor;
        new_hold = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.wr) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      out_ch_r   <= cmd.ch;
      out_lvl_r  <= new_lvl;
      out_pk_r   <= new_pk;
      out_hold_r <= new_hold;
      out_last_r <= cmd.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_channel_index = out_ch_r;
  assign out_level         = out_lvl_r;
  assign out_peak          = out_pk_r;
  assign out_hold          = out_hold_r;
  assign out_last          = out_last_r;

endmodule

@@ rtl/peak_hold_level_meter.sv @@
// Top level of the multi-channel peak hold level meter.
//
//   channel  direction  transfer moves
//   in_ch    sink       mode, channel, level_db, time_ms
//   out_ch   source     channel_index, level_out, peak_out, hold_out, last
//   cfg_ch   sink       index, data (always ready)
//
// An observe request updates one channel; decay and clear walk every active
// channel. Each channel is a read-modify-write of the single-port state
// memory: a registered read, a registered rate product, then the update and write.
// Reset returns the registers to their defaults and marks every channel as unwritten,
// so no clearing pass is needed. A stalled result holds the update step of the next
// channel; a new request is taken while the last result still waits.
module peak_hold_level_meter import phlm_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  phlm_in_if.sink    in_ch,
  phlm_out_if.source out_ch,
  phlm_cfg_if.sink   cfg_ch
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ch.ready = 1'b1;

  phlm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_mode    (in_ch.mode),
    .in_channel (in_ch.channel),
    .in_ready   (in_ch.ready),
    .status     (status),
    .cmd        (cmd)
  );

  phlm_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_ch.valid),
    .cfg_index         (cfg_ch.index),
    .cfg_data          (cfg_ch.data),
    .in_mode           (in_ch.mode),
    .in_level_db       (in_ch.level_db),
    .in_time_ms        (in_ch.time_ms),
    .cmd               (cmd),
    .status            (status),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_channel_index (out_ch.channel_index),
    .out_level         (out_ch.level_out),
    .out_peak          (out_ch.peak_out),
    .out_hold          (out_ch.hold_out),
    .out_last          (out_ch.last)
  );

endmodule

@@ rtl/phlm_checker.sv @@
// Port-level checker of the level meter and its bind to the top level.
module phlm_checker import phlm_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic [1:0]      in_mode,
  input logic            out_valid,
  input logic            out_ready,
  input logic [CH_W-1:0] out_channel_index,
  input logic            out_last
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // A request with a defined mode keeps the input closed while it is worked on.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode != MODE_UNUSED) |=> !in_ready)
    else $error("input open while a request is in progress");

  // Within one walk, results follow in ascending channel order.
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      !out_valid || (out_channel_index == CH_W'($past(out_channel_index) + 1'b1)))
    else $error("walk results out of order");

endmodule

bind peak_hold_level_meter phlm_checker u_phlm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_mode           (in_ch.mode),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_channel_index (out_ch.channel_index),
  .out_last          (out_ch.last)
);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the peak hold level meter: queued requests, a predictor, a checker.
module testbench;
  import phlm_pkg::*;

  localparam int         DRAIN_CYCLES = 4 + 3 * CHANNELS + 10;
  localparam int         QUIET_LIMIT  = 4000;
  localparam int         STALL_CYCLES = 400;
  localparam int         IDLE_PCT     = 18;

  typedef struct packed {
    logic [1:0]      mode;
    logic [CH_W-1:0] channel;
    logic [DB_W-1:0] level_db;
    logic [MS_W-1:0] time_ms;
  } meter_req_t;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic [DB_W-1:0] level;
    logic [DB_W-1:0] peak;
    logic [MS_W-1:0] hold;
    logic            last;
  } meter_reading_t;

  logic clk = 1'b0;
  logic rst_n;

  phlm_in_if  in_ch ();
  phlm_out_if out_ch ();
  phlm_cfg_if cfg_ch ();

  peak_hold_level_meter i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  meter_req_t     meter_reqs[$];
  meter_reading_t due_readings[$];
  meter_req_t     on_bus;
  meter_reading_t want_r;

  int level_st[CHANNELS];
  int peak_st[CHANNELS];
  int hold_st[CHANNELS];
  int floor_reg;
  int lrate_reg;
  int prate_reg;
  int hold_reg;
  int active_reg;

  int errors;
  int quiet_cycles;
  int hold_off_left;
  bit stall_done;
  bit stall_arm;
  bit idle_on = 1'b1;

  function automatic int floor_eff();
    return (floor_reg > 0) ? 0 : floor_reg;
  endfunction

  function automatic int active_n();
    int n;
    n = active_reg;
    if (n == 0) n = 1;
    if (n > CHANNELS) n = CHANNELS;
    return n;
  endfunction

  function automatic int clamp_floor(int v);
    int f;
    f = floor_eff();
    return (v < f) ? f : v;
  endfunction

  function automatic int rate_fall(int rate, int ms);
    logic [31:0] p;
    p = rate * ms;
    return int'(p >> 8);
  endfunction

  function automatic void note_reading(int ch, bit last);
    meter_reading_t r;
    r.ch    = ch[CH_W-1:0];
    r.level = level_st[ch][DB_W-1:0];
    r.peak  = peak_st[ch][DB_W-1:0];
    r.hold  = hold_st[ch][MS_W-1:0];
    r.last  = last;
    due_readings.push_back(r);
  endfunction

  function automatic void set_reg(cfg_reg_t idx, int v);
    case (idx)
      CFG_FLOOR:      floor_reg  = int'($signed(v[DB_W-1:0]));
      CFG_LEVEL_RATE: lrate_reg  = v & 'hFFFF;
      CFG_PEAK_RATE:  prate_reg  = v & 'hFFFF;
      CFG_HOLD_TIME:  hold_reg   = v & 'hFFFF;
      CFG_ACTIVE:     active_reg = v & 'h7F;
      default: ;
    endcase
  endfunction

  function automatic void meter_update(meter_req_t rq);
    int f, n, db, t_ms, ch, cand, over, held, left;
    f    = floor_eff();
    n    = active_n();
    db   = int'($signed(rq.level_db));
    t_ms = int'(rq.time_ms);
    ch   = int'(rq.channel);
    case (rq.mode)
      MODE_OBSERVE: begin
        if (db < f) db = f;
        if (db > 0) db = 0;
        cand = clamp_floor(db - rate_fall(lrate_reg, t_ms));
        if (cand > level_st[ch]) level_st[ch] = cand;
        over = (t_ms > hold_reg) ? t_ms - hold_reg : 0;
        held = db - rate_fall(prate_reg, over);
        // The comparison uses the aged peak before it is held at the floor.
        if (held >= peak_st[ch] && db > f) begin
          left = (hold_reg > t_ms) ? hold_reg - t_ms : 0;
          if (held > peak_st[ch]) hold_st[ch] = left;
          else if (left > hold_st[ch]) hold_st[ch] = left;
          peak_st[ch] = clamp_floor(held);
        end
        note_reading(ch, 1'b1);
      end
      MODE_DECAY: begin
        for (int i = 0; i < n; i++) begin
          over = (t_ms > hold_st[i]) ? t_ms - hold_st[i] : 0;
          level_st[i] = clamp_floor(level_st[i] - rate_fall(lrate_reg, t_ms));
          peak_st[i]  = clamp_floor(peak_st[i] - rate_fall(prate_reg, over));
          hold_st[i]  = (hold_st[i] > t_ms) ? hold_st[i] - t_ms : 0;
          note_reading(i, i + 1 == n);
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < n; i++) begin
          level_st[i] = f;
          peak_st[i]  = f;
          hold_st[i]  = 0;
          note_reading(i, i + 1 == n);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_req(logic [1:0] mode, int ch, int db, int t_ms);
    meter_req_t rq;
    rq.mode     = mode;
    rq.channel  = ch[CH_W-1:0];
    rq.level_db = db[DB_W-1:0];
    rq.time_ms  = t_ms[MS_W-1:0];
    meter_reqs.push_back(rq);
  endfunction

  function automatic void add_random(int count);
    int made, r, lo, ch, db, t_ms;
    made = 0;
    lo   = floor_eff();
    while (made < count) begin
      r = $urandom_range(99);
      case ($urandom_range(9))
        0:       t_ms = $urandom_range(65535);
        1, 2:    t_ms = $urandom_range(50);
        default: t_ms = $urandom_range(3000);
      endcase
      ch = ($urandom_range(7) == 0) ? $urandom_range(CHANNELS - 1) :
                                      $urandom_range(active_n() - 1);
      db = ($urandom_range(4) == 0) ? $urandom_range(65535) : lo + $urandom_range(-lo);
      if (r < 60) begin
        queue_req(MODE_OBSERVE, ch, db, t_ms);
        made++;
      end else if (r < 85) begin
        queue_req(MODE_DECAY, ch, db, t_ms);
        made++;
      end else if (r < 94) begin
        queue_req(MODE_CLEAR, ch, db, t_ms);
        made++;
      end else begin
        queue_req(MODE_UNUSED, ch, db, t_ms);
      end
    end
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (meter_reqs.size() != 0 || in_ch.valid || due_readings.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_settings(int fl, int lr, int pr, int ht, int ac);
    cfg_reg_t order[5];
    int       vals[5];
    order = '{CFG_FLOOR, CFG_LEVEL_RATE, CFG_PEAK_RATE, CFG_HOLD_TIME, CFG_ACTIVE};
    vals  = '{fl, lr, pr, ht, ac};
    @(posedge clk);
    for (int r = 0; r < 5; r++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= order[r];
      cfg_ch.data  <= vals[r][CFG_DAT_W-1:0];
      do @(posedge clk);
      while (!cfg_ch.ready);
      set_reg(order[r], vals[r]);
    end
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) meter_update(on_bus);
      if (!in_ch.valid || in_ch.ready) begin
        if (meter_reqs.size() != 0 && !(idle_on && $urandom_range(99) < IDLE_PCT)) begin
          on_bus = meter_reqs.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.mode     <= on_bus.mode;
          in_ch.channel  <= on_bus.channel;
          in_ch.level_db <= on_bus.level_db;
          in_ch.time_ms  <= on_bus.time_ms;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_readings.size() == 0) begin
          $error("result transfer for channel %0d with no result expected",
                 out_ch.channel_index);
          errors++;
        end else begin
          want_r = due_readings.pop_front();
          check_field("channel_index", want_r.ch, out_ch.channel_index);
          check_field("level_out", $signed(want_r.level), out_ch.level_out);
          check_field("peak_out", $signed(want_r.peak), out_ch.peak_out);
          check_field("hold_out", want_r.hold, out_ch.hold_out);
          check_field("last", want_r.last, out_ch.last);
        end
      end
      if (stall_arm && !stall_done) begin
        hold_off_left = STALL_CYCLES;
        stall_done    = 1'b1;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no transfer for %0d cycles", QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.mode     = '0;
    in_ch.channel  = '0;
    in_ch.level_db = '0;
    in_ch.time_ms  = '0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = CFG_FLOOR;
    cfg_ch.data    = '0;
    rst_n          = 1'b0;
    floor_reg  = RST_FLOOR;
    lrate_reg  = RST_LEVEL_RATE;
    prate_reg  = RST_PEAK_RATE;
    hold_reg   = RST_HOLD_TIME;
    active_reg = RST_ACTIVE;
    for (int i = 0; i < CHANNELS; i++) begin
      level_st[i] = RST_FLOOR;
      peak_st[i]  = RST_FLOOR;
      hold_st[i]  = 0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    queue_req(MODE_CLEAR, 0, 0, 0);
    queue_req(MODE_OBSERVE, 0, 0, 0);
    queue_req(MODE_OBSERVE, 1, 32767, 0);
    queue_req(MODE_OBSERVE, 1, -32768, 0);
    queue_req(MODE_OBSERVE, 2, -15360, 0);
    queue_req(MODE_OBSERVE, 0, 0, 200);
    queue_req(MODE_DECAY, 0, 0, 1000);
    queue_req(MODE_OBSERVE, 0, 0, 100);
    queue_req(MODE_OBSERVE, 3, -256, 65535);
    queue_req(MODE_OBSERVE, 1, -3000, 1600);
    queue_req(MODE_DECAY, 63, -1, 0);
    queue_req(MODE_UNUSED, 63, -1, 65535);
    queue_req(MODE_DECAY, 0, 0, 65535);
    queue_req(MODE_OBSERVE, 63, -1, 1);
    queue_req(MODE_OBSERVE, 42, 12345, 40000);
    queue_req(MODE_CLEAR, 21, -12345, 777);
    wait_idle();

    idle_on = 1'b0;
    write_settings(-32768, 65535, 65535, 0, CHANNELS);
    add_random(30);
    wait_idle();

    idle_on = 1'b1;
    write_settings(32767, 0, 0, 65535, 0);
    add_random(30);
    wait_idle();

    write_settings(-6000, 1000, 3000, 300, 5);
    add_random(35);
    wait_idle();

    write_settings(-$urandom_range(32768), $urandom_range(65535), $urandom_range(65535),
                   $urandom_range(2000), $urandom_range(127));
    add_random(30);
    wait_idle();

    // The result side holds off for a long stretch while requests keep coming.
    write_settings(RST_FLOOR, RST_LEVEL_RATE, RST_PEAK_RATE, RST_HOLD_TIME, 100);
    stall_arm = 1'b1;
    add_random(30);
    wait_idle();

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ peak_hold_level_meter.f @@
rtl/phlm_pkg.sv
rtl/phlm_in_if.sv
rtl/phlm_out_if.sv
rtl/phlm_cfg_if.sv
rtl/phlm_ctrl.sv
rtl/phlm_dp.sv
rtl/peak_hold_level_meter.sv
rtl/phlm_checker.sv
tb/testbench.sv
